@@ hdl/rdtt_pkg.sv @@
// Shared types, codes and constants for the repeating delay task timer.
// No dependencies; the top level and the checker import this package.
package rdtt_pkg;

	localparam int TABLE_SLOTS_DEF   = 32;
	localparam int PENDING_DEPTH_DEF = 20;
	localparam int CLOCK_WRAP        = 100;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic [1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [1:0] KIND_ADD_FULL = 2'd1;
	localparam logic [1:0] KIND_FIRED    = 2'd2;
	localparam logic [1:0] KIND_TICK     = 2'd3;

	typedef struct packed {
		logic        action;
		logic [15:0] delay_ticks;
		logic [15:0] repeat_count;
		logic [7:0]  task_tag;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  fired_tag;
		logic [15:0] remaining;
		logic        last;
		logic [15:0] seconds;
		logic [6:0]  hundredths;
	} res_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [15:0] delay;
		logic [15:0] elapsed;
		logic [15:0] count;
		logic [7:0]  tag;
	} entry_t;

	// one queued add as held in the pending memory
	typedef struct packed {
		logic [15:0] delay;
		logic [15:0] count;
		logic [7:0]  tag;
	} pend_t;

endpackage

@@ hdl/rdtt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/rdtt_free_finder.sv @@
// Lowest free slot of the timer table, from the in-use flags.
// No dependencies.
module rdtt_free_finder #(
	parameter int SLOTS = 32,
	parameter int SW    = $clog2(SLOTS)
) (
	input  logic [SLOTS-1:0] in_use,
	output logic [SW-1:0]    slot
);

	always_comb begin
		slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use[i])
				slot = SW'(i);
		end
	end

endmodule

@@ hdl/repeating_delay_task_timer.sv @@
// Top level of the repeating delay task timer.
// Uses rdtt_pkg, rdtt_ram and rdtt_free_finder.
//
// Timing for a user: an add item gives its single result on the cycle after it is taken,
// and busy stays low, so adds may follow every cycle while no tick is in progress. A tick
// item holds busy while it moves the adds queued since the last tick into the table, a read
// of the pending memory and a table write per add, and then walks the table entries; every
// walk step is a read of the entry and link memories followed by a write-back. Results come
// on result with result_valid high for exactly one cycle each: firings in list order, then
// tick done with last set. There is no back-pressure, so the receiver must take every
// result.
// No memory needs clearing after reset: only the in-use flags and control registers are reset.
module repeating_delay_task_timer
	import rdtt_pkg::*;
#(
	parameter int TABLE_SLOTS   = rdtt_pkg::TABLE_SLOTS_DEF,
	parameter int PENDING_DEPTH = rdtt_pkg::PENDING_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rdtt_pkg::cmd_t  cmd,
	output logic            result_valid,
	output rdtt_pkg::res_t  result
);

	localparam int SW  = $clog2(TABLE_SLOTS);
	localparam int AW  = $clog2(TABLE_SLOTS + 1);
	localparam int PW  = $clog2(PENDING_DEPTH + 1);
	localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW  = AW + PW;
	localparam int EW  = $bits(entry_t);
	localparam int QW  = $bits(pend_t);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MV_RD = 3'd1;  // read next queued add
	localparam logic [2:0] S_MV_WR = 3'd2;  // write it into the table
	localparam logic [2:0] S_WK_RD = 3'd3;  // read entry under the walk pointer
	localparam logic [2:0] S_WK_EX = 3'd4;  // update, write back, maybe unlink
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]             state_q;
	logic [TABLE_SLOTS-1:0] in_use_q;
	logic [SW-1:0]          first_q, last_q, cur_q, prev_q;
	logic                   have_prev_q;
	logic [AW-1:0]          active_q, visit_q;
	logic [PW-1:0]          pend_q, mv_q;
	logic [6:0]             hund_q;
	logic [15:0]            sec_q;
	res_t                   res_q;
	logic                   res_valid_q;

	// memory ports
	logic           e_we, l_we, p_we;
	logic [SW-1:0]  e_waddr, e_raddr, l_waddr, l_raddr, l_wdata, l_rdata;
	entry_t         e_wdata, e_rdata;
	logic [PAW-1:0] p_waddr, p_raddr;
	pend_t          p_wdata, p_rdata;
	logic [SW-1:0]  free_slot;

	logic           accept, full;
	logic [CW-1:0]  occupied;

	// walk step
	logic           fire, drop;
	logic [15:0]    cnt_n, el_n;

	rdtt_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_entry_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	rdtt_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_link_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	rdtt_ram #(.WIDTH(QW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	rdtt_free_finder #(.SLOTS(TABLE_SLOTS)) u_free (
		.in_use(in_use_q), .slot(free_slot)
	);

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// an add is refused when the queue is full or table plus queue already fill the table
	assign occupied = CW'(active_q) + CW'(pend_q);
	assign full     = (pend_q >= PW'(PENDING_DEPTH)) || (occupied >= CW'(TABLE_SLOTS));

	// zero count drops without firing; otherwise fire on zero delay or elapsed match
	always_comb begin
		fire  = 1'b0;
		cnt_n = e_rdata.count;
		el_n  = e_rdata.elapsed + 16'd1;
		if (e_rdata.count != 16'd0) begin
			fire = (e_rdata.delay == 16'd0) || (e_rdata.elapsed == e_rdata.delay);
			if (fire) begin
				cnt_n = e_rdata.count - 16'd1;
				el_n  = 16'd1;
			end
		end
		drop = (cnt_n == 16'd0);
	end

	always_comb begin
		p_we    = accept && (cmd.action == ACT_ADD) && !full;
		p_waddr = pend_q[PAW-1:0];
		p_wdata = '{delay: cmd.delay_ticks, count: cmd.repeat_count, tag: cmd.task_tag};
		p_raddr = mv_q[PAW-1:0];

		e_we    = 1'b0;
		e_waddr = cur_q;
		e_wdata = '{delay: e_rdata.delay, elapsed: el_n, count: cnt_n, tag: e_rdata.tag};
		e_raddr = cur_q;
		l_we    = 1'b0;
		l_waddr = prev_q;
		l_wdata = l_rdata;
		l_raddr = cur_q;

		unique case (state_q)
			S_MV_WR: begin
				e_we    = 1'b1;
				e_waddr = free_slot;
				e_wdata = '{delay: p_rdata.delay, elapsed: 16'd0,
				            count: p_rdata.count, tag: p_rdata.tag};
				// chain the new entry behind the current tail
				l_we    = (active_q != '0);
				l_waddr = last_q;
				l_wdata = free_slot;
			end
			S_WK_EX: begin
				e_we = 1'b1;
				// unlink from the predecessor; the head case is a register update
				l_we = drop && have_prev_q;
			end
			S_IDLE, S_MV_RD, S_WK_RD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			first_q     <= '0;
			last_q      <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			active_q    <= '0;
			visit_q     <= '0;
			pend_q      <= '0;
			mv_q        <= '0;
			hund_q      <= '0;
			sec_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.action == ACT_ADD) begin
							if (!full)
								pend_q <= pend_q + PW'(1);
							res_valid_q <= 1'b1;
							res_q <= '{kind: full ? KIND_ADD_FULL : KIND_ADD_OK,
							           fired_tag: cmd.task_tag,
							           remaining: cmd.repeat_count, last: 1'b1,
							           seconds: sec_q, hundredths: hund_q};
						end else begin
							if (hund_q == 7'(CLOCK_WRAP - 1)) begin
								hund_q <= '0;
								sec_q  <= sec_q + 16'd1;
							end else begin
								hund_q <= hund_q + 7'd1;
							end
							mv_q    <= '0;
							state_q <= S_MV_RD;
						end
					end
				end
				S_MV_RD: begin
					if (mv_q == pend_q) begin
						pend_q      <= '0;
						cur_q       <= first_q;
						visit_q     <= active_q;
						have_prev_q <= 1'b0;
						state_q     <= S_WK_RD;
					end else begin
						state_q <= S_MV_WR;
					end
				end
				S_MV_WR: begin
					in_use_q[free_slot] <= 1'b1;
					if (active_q == '0)
						first_q <= free_slot;
					last_q   <= free_slot;
					active_q <= active_q + AW'(1);
					mv_q     <= mv_q + PW'(1);
					state_q  <= S_MV_RD;
				end
				S_WK_RD: begin
					state_q <= (visit_q == '0) ? S_DONE : S_WK_EX;
				end
				S_WK_EX: begin
					if (fire) begin
						res_valid_q <= 1'b1;
						res_q <= '{kind: KIND_FIRED, fired_tag: e_rdata.tag,
						           remaining: cnt_n, last: 1'b0,
						           seconds: sec_q, hundredths: hund_q};
					end
					if (drop) begin
						if (!have_prev_q)
							first_q <= l_rdata;
						if (cur_q == last_q)
							last_q <= have_prev_q ? prev_q : '0;
						in_use_q[cur_q] <= 1'b0;
						active_q <= active_q - AW'(1);
					end else begin
						prev_q      <= cur_q;
						have_prev_q <= 1'b1;
					end
					cur_q   <= l_rdata;
					visit_q <= visit_q - AW'(1);
					state_q <= S_WK_RD;
				end
				S_DONE: begin
					if (active_q == '0) begin
						first_q <= '0;
						last_q  <= '0;
					end
					res_valid_q <= 1'b1;
					res_q <= '{kind: KIND_TICK, fired_tag: 8'd0, remaining: 16'd0,
					           last: 1'b1, seconds: sec_q, hundredths: hund_q};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/rdtt_checker.sv @@
// Port-level checks for the repeating delay task timer, bound to the top level.
// Uses rdtt_pkg; follows repeating_delay_task_timer in compile order.
module rdtt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input rdtt_pkg::cmd_t cmd,
	input logic           result_valid,
	input rdtt_pkg::res_t result
);
	import rdtt_pkg::*;

	// an add is answered on the very next cycle with a final result
	a_add_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == ACT_ADD |=> result_valid && result.last)
		else $error("add not answered next cycle");

	// only firings are non-final
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.kind == KIND_FIRED)
		else $error("non-final result is not a firing");

	a_fired_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_FIRED |-> busy)
		else $error("firing reported while idle");

	a_tick_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_TICK |-> result.fired_tag == 8'd0
			&& result.remaining == 16'd0 && !busy)
		else $error("tick done malformed");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.hundredths < 7'(CLOCK_WRAP))
		else $error("hundredths out of range");

endmodule

bind repeating_delay_task_timer rdtt_checker u_rdtt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.result_valid(result_valid), .result(result)
);
